### design/tpa_pkg.sv
`timescale 1ns / 1ps

package tpa_pkg;

    // Default history length; the year index saturates at one below it.
    localparam int MAX_YEARS_DEF = 64;

    // One in Q.16.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Saturation limit of the prior infection count.
    localparam logic [6:0] COUNT_MAX = 7'd127;

    // Command queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_LONG_GAIN  = 3'd0;
    localparam logic [2:0] REG_SHORT_GAIN = 3'd1;
    localparam logic [2:0] REG_SENIORITY  = 3'd2;
    localparam logic [2:0] REG_WANE       = 3'd3;
    localparam logic [2:0] REG_TEST_YEAR  = 3'd4;

    // One classified year, handed from the front to the back.
    typedef struct packed {
        logic        counted;
        logic [19:0] long_cross;
        logic [19:0] short_cross;
        logic [6:0]  sen_steps;
        logic [6:0]  wane_steps;
        logic        last;
    } tpa_cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SHORT,
        BK_INNER,
        BK_SCALE,
        BK_ACC
    } tpa_back_state_t;

    // max(0, 1 - rate*steps) in Q.16.
    function automatic logic [16:0] linear_drop(input logic [19:0] rate,
                                                input logic [6:0]  steps);
        logic [26:0] prod;
        prod = rate * steps;
        if (prod >= 27'(ONE_Q16))
        begin
            linear_drop = 17'd0;
        end
        else
        begin
            linear_drop = ONE_Q16 - prod[16:0];
        end
    endfunction

endpackage

### design/tpa_front.sv
`timescale 1ns / 1ps

module tpa_front #(
    parameter int MAX_YEARS = tpa_pkg::MAX_YEARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [6:0]         test_year,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               infected,
    input  logic [19:0]        long_cross,
    input  logic [19:0]        short_cross,
    input  logic               last_year,
    output logic               push,
    output tpa_pkg::tpa_cmd_t  push_data,
    input  logic               queue_full
);

    localparam int YW    = $clog2(MAX_YEARS);
    localparam int CMP_W = (YW + 1 > 8) ? YW + 1 : 8;
    localparam logic [YW-1:0] YEAR_LAST = YW'(MAX_YEARS - 1);

    logic [YW-1:0]    year_index_reg;
    logic [YW-1:0]    year_index_next;
    logic [6:0]       count_reg;
    logic [6:0]       count_next;
    logic [6:0]       count_upd;
    logic [CMP_W-1:0] year_one;
    logic [CMP_W-1:0] test_ext;
    logic [CMP_W-1:0] wane_diff;
    logic             counted;
    logic             accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // Mask years after the test year and work out the waning distance.
    assign year_one  = CMP_W'(year_index_reg) + CMP_W'(1);
    assign test_ext  = CMP_W'(test_year);
    assign counted   = infected && (year_one <= test_ext);
    assign wane_diff = test_ext - year_one;

    // Count this infection, saturating.
    assign count_upd = (counted && (count_reg < tpa_pkg::COUNT_MAX)) ?
                       count_reg + 7'd1 : count_reg;

    always_comb
    begin
        push_data.counted     = counted;
        push_data.long_cross  = long_cross;
        push_data.short_cross = short_cross;
        push_data.sen_steps   = count_upd - 7'd1;
        push_data.wane_steps  = wane_diff[6:0];
        push_data.last        = last_year;
    end

    // Strain position: cleared at the end of a strain, index saturates.
    always_comb
    begin
        year_index_next = year_index_reg;
        count_next      = count_reg;
        if (accept)
        begin
            if (last_year)
            begin
                year_index_next = '0;
                count_next      = '0;
            end
            else
            begin
                count_next = count_upd;
                if (year_index_reg != YEAR_LAST)
                begin
                    year_index_next = year_index_reg + YW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_index_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            year_index_reg <= year_index_next;
            count_reg      <= count_next;
        end
    end

endmodule

### design/tpa_queue.sv
`timescale 1ns / 1ps

module tpa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tpa_pkg::tpa_cmd_t  push_data,
    output logic               full,
    input  logic               pop,
    output tpa_pkg::tpa_cmd_t  pop_data,
    output logic               empty
);

    tpa_pkg::tpa_cmd_t                  entry_reg [tpa_pkg::QUEUE_DEPTH];
    logic [tpa_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [tpa_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [tpa_pkg::QUEUE_CW-1:0]       fill_reg;
    logic                               do_push;
    logic                               do_pop;

    assign full     = (fill_reg == tpa_pkg::QUEUE_CW'(tpa_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tpa_pkg::QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tpa_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + tpa_pkg::QUEUE_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - tpa_pkg::QUEUE_CW'(1);
            end
        end
    end

endmodule

### design/tpa_back.sv
`timescale 1ns / 1ps

module tpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        long_term_gain,
    input  logic [23:0]        short_term_gain,
    input  logic [19:0]        seniority_rate,
    input  logic [19:0]        wane_rate,
    input  logic               queue_empty,
    input  tpa_pkg::tpa_cmd_t  cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        contribution,
    output logic [39:0]        strain_titre,
    output logic               done_res
);

    tpa_pkg::tpa_back_state_t state_reg;
    tpa_pkg::tpa_back_state_t state_next;

    logic        ld_short;
    logic        ld_inner;
    logic        ld_scale;
    logic        ld_out;

    logic [16:0] sen_reg;
    logic [16:0] wf_reg;
    logic [43:0] p_long_reg;
    logic [43:0] p_short_reg;
    logic        last_reg;
    logic [60:0] q_reg;
    logic [45:0] inner_reg;
    logic [62:0] prod_reg;
    logic [39:0] sum_reg;
    logic        out_valid_reg;
    logic [31:0] contrib_reg;
    logic [39:0] titre_reg;
    logic        done_reg;

    logic [31:0] contrib_val;
    logic [40:0] sum_wide;
    logic [39:0] sum_sat;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpa_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and step enables.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ld_short   = 1'b0;
        ld_inner   = 1'b0;
        ld_scale   = 1'b0;
        ld_out     = 1'b0;
        case (state_reg)
            tpa_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = tpa_pkg::BK_SHORT;
                end
            end
            tpa_pkg::BK_SHORT:
            begin
                ld_short   = 1'b1;
                state_next = tpa_pkg::BK_INNER;
            end
            tpa_pkg::BK_INNER:
            begin
                ld_inner   = 1'b1;
                state_next = tpa_pkg::BK_SCALE;
            end
            tpa_pkg::BK_SCALE:
            begin
                ld_scale   = 1'b1;
                state_next = tpa_pkg::BK_ACC;
            end
            tpa_pkg::BK_ACC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ld_out     = 1'b1;
                    state_next = tpa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tpa_pkg::BK_IDLE;
            end
        endcase
    end

    // Seniority and waning factors, and the two gain products.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sen_reg     <= cmd.counted ?
                           tpa_pkg::linear_drop(seniority_rate, cmd.sen_steps) : 17'd0;
            wf_reg      <= tpa_pkg::linear_drop(wane_rate, cmd.wane_steps);
            p_long_reg  <= long_term_gain * cmd.long_cross;
            p_short_reg <= short_term_gain * cmd.short_cross;
            last_reg    <= cmd.last;
        end
    end

    // Waned short-term boost, sum of boosts, then the seniority scaling.
    always_ff @(posedge clk)
    begin
        if (ld_short)
        begin
            q_reg <= p_short_reg * wf_reg;
        end
        if (ld_inner)
        begin
            inner_reg <= {2'b00, p_long_reg} + {1'b0, q_reg[60:16]};
        end
        if (ld_scale)
        begin
            prod_reg <= sen_reg * inner_reg;
        end
    end

    // Contribution fits in 31 bits, so it needs no 32-bit saturation.
    assign contrib_val = {1'b0, prod_reg[62:32]};
    assign sum_wide    = {1'b0, sum_reg} + {9'd0, contrib_val};
    assign sum_sat     = sum_wide[40] ? {40{1'b1}} : sum_wide[39:0];

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            contrib_reg <= contrib_val;
            titre_reg   <= last_reg ? sum_sat : 40'd0;
            done_reg    <= last_reg;
        end
    end

    // Running sum and output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_out)
            begin
                sum_reg <= last_reg ? 40'd0 : sum_sat;
            end
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign contribution = contrib_reg;
    assign strain_titre = titre_reg;
    assign done_res     = done_reg;

endmodule

### design/titre_prediction_accumulator.sv
`timescale 1ns / 1ps

// Each accepted input beat enters the command queue; the back-end sequencer takes
// one year at a time and finishes it before popping the next (factors,
// short-term product, sum, seniority scaling, accumulate; accumulate waits while
// an output beat is pending). A two-entry command queue lets the input keep taking beats meanwhile, until it is full.
// Reset (rst_n, asynchronous, active low) clears strain state and loads defaults.
module titre_prediction_accumulator #(
    parameter int MAX_YEARS = tpa_pkg::MAX_YEARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [0] infected, [20:1] long_cross,
                                        // [40:21] short_cross, [47:41] zero
    input  logic        s_axis_tlast,   // last_year
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] contribution, [71:32] strain_titre
    output logic        m_axis_tlast,   // done_res
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0]       long_gain_reg;
    logic [23:0]       short_gain_reg;
    logic [19:0]       seniority_reg;
    logic [19:0]       wane_reg;
    logic [6:0]        test_year_reg;
    logic [2:0]        reg_index;
    logic              cfg_write;

    logic              push;
    tpa_pkg::tpa_cmd_t push_data;
    logic              queue_full;
    logic              pop;
    tpa_pkg::tpa_cmd_t pop_data;
    logic              queue_empty;
    logic [31:0]       contribution;
    logic [39:0]       strain_titre;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_gain_reg  <= 24'd65536;
            short_gain_reg <= 24'd65536;
            seniority_reg  <= 20'd0;
            wane_reg       <= 20'd0;
            test_year_reg  <= 7'd1;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                tpa_pkg::REG_LONG_GAIN:  long_gain_reg  <= pwdata[23:0];
                tpa_pkg::REG_SHORT_GAIN: short_gain_reg <= pwdata[23:0];
                tpa_pkg::REG_SENIORITY:  seniority_reg  <= pwdata[19:0];
                tpa_pkg::REG_WANE:       wane_reg       <= pwdata[19:0];
                tpa_pkg::REG_TEST_YEAR:  test_year_reg  <= pwdata[6:0];
                default:                 ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            tpa_pkg::REG_LONG_GAIN:  prdata = {8'd0, long_gain_reg};
            tpa_pkg::REG_SHORT_GAIN: prdata = {8'd0, short_gain_reg};
            tpa_pkg::REG_SENIORITY:  prdata = {12'd0, seniority_reg};
            tpa_pkg::REG_WANE:       prdata = {12'd0, wane_reg};
            tpa_pkg::REG_TEST_YEAR:  prdata = {25'd0, test_year_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    tpa_front #(
        .MAX_YEARS (MAX_YEARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .test_year   (test_year_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .infected    (s_axis_tdata[0]),
        .long_cross  (s_axis_tdata[20:1]),
        .short_cross (s_axis_tdata[40:21]),
        .last_year   (s_axis_tlast),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (queue_full)
    );

    tpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    tpa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .long_term_gain  (long_gain_reg),
        .short_term_gain (short_gain_reg),
        .seniority_rate  (seniority_reg),
        .wane_rate       (wane_reg),
        .queue_empty     (queue_empty),
        .cmd             (pop_data),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .contribution    (contribution),
        .strain_titre    (strain_titre),
        .done_res        (m_axis_tlast)
    );

    assign m_axis_tdata = {strain_titre, contribution};

endmodule
